FILE: sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and helpers for the stream find-and-replace unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	// Sizes
	localparam int CHAR_W      = 16;
	localparam int MAX_PATTERN = 8;
	localparam int MAX_REPLACE = 8;
	localparam int MAX_RESULTS = 8;
	localparam int LEN_W       = $clog2(MAX_RESULTS + 1);   // lengths 0..8
	localparam int POS_W       = $clog2(MAX_PATTERN);       // window index
	localparam int IDX_W       = $clog2(MAX_RESULTS);       // result index in a job
	localparam int CNT_W       = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 16'h0041;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 16'h005A;
	localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 16'h0020;
	localparam logic [CNT_W-1:0]  CNT_MAX = '1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_REPLACE_LOW  = 3'd2,
		REG_REPLACE_HIGH = 3'd3,
		REG_PATTERN_LEN  = 3'd4,
		REG_REPLACE_LEN  = 3'd5,
		REG_IGNORE_CASE  = 3'd6
	} cfg_reg_t;

	// Current configuration, characters unpacked (element 0 is character 0)
	typedef struct packed {
		logic [MAX_PATTERN-1:0][CHAR_W-1:0] pattern;
		logic [MAX_REPLACE-1:0][CHAR_W-1:0] replace;
		logic [LEN_W-1:0]                   pattern_len;
		logic [LEN_W-1:0]                   replace_len;
		logic                               ignore_case;
	} cfg_t;

	// One classified input item: the results it causes
	typedef struct packed {
		logic [MAX_RESULTS-1:0][CHAR_W-1:0] chars;
		logic [IDX_W-1:0]                   nm1;       // result count minus one
		logic                               has_char;  // 0 for the empty end marker
		logic                               last;
		logic [CNT_W-1:0]                   count;
	} job_t;

	// Front status seen by the top level
	typedef struct packed {
		logic [POS_W-1:0] fill;
		logic [CNT_W-1:0] match_cnt;
	} front_stat_t;

	// ASCII-only fold to lower case
	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c,
		input logic ic);
		if (ic && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
			return c + ASCII_CASE_OFS;
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: sv/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels of the stream find-and-replace unit.
// ----------------------------------------------------------------------------
`default_nettype none

// Input characters
interface sfr_in_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] in_char;
	logic              in_last;

	modport source (output valid, in_char, in_last, input ready);
	modport sink   (input valid, in_char, in_last, output ready);
endinterface

// Result items
interface sfr_out_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              has_char;
	logic              out_last;
	logic [CNT_W-1:0]  match_count;

	modport source (output valid, out_char, has_char, out_last, match_count,
		input ready);
	modport sink   (input valid, out_char, has_char, out_last, match_count,
		output ready);
endinterface

// Configuration writes
interface sfr_cfg_if import sfr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Accepts characters, keeps the match window, compares it with the pattern
// and pushes a job of up to eight results when a character yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front import sfr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sfr_in_if.sink       feed,
	input  wire cfg_t    cfg,
	input  wire logic    q_full,
	output logic         push,
	output job_t         push_job,
	output front_stat_t  stat
);

	logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_q;
	logic [POS_W-1:0]                   fill_q;
	logic [CNT_W-1:0]                   matches_q;

	logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_new;
	logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_shift;
	logic [LEN_W-1:0]                   fill_ext, fill_new, plen, rlen, nres;
	logic                               accept, cmp, hit, do_shift;
	logic [CNT_W-1:0]                   matches_new;

	assign feed.ready = !q_full;
	assign accept     = feed.valid && feed.ready;

	// Effective lengths
	always_comb begin
		if (cfg.pattern_len == '0)
			plen = LEN_W'(1);
		else if (cfg.pattern_len > LEN_W'(MAX_PATTERN))
			plen = LEN_W'(MAX_PATTERN);
		else
			plen = cfg.pattern_len;
		if (cfg.replace_len > LEN_W'(MAX_REPLACE))
			rlen = LEN_W'(MAX_REPLACE);
		else
			rlen = cfg.replace_len;
	end

	// Append, compare all positions in parallel, build the shifted window
	always_comb begin
		fill_ext = {1'b0, fill_q};
		fill_new = fill_ext + LEN_W'(1);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_new[i] = (LEN_W'(i) == fill_ext) ? feed.in_char : win_q[i];
		end
		cmp = (fill_new >= plen);
		hit = cmp;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (LEN_W'(i) < plen &&
				fold(win_new[i], cfg.ignore_case) != fold(cfg.pattern[i], cfg.ignore_case))
				hit = 1'b0;
		end
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			win_shift[i] = win_new[i+1];
		end
		win_shift[MAX_PATTERN-1] = win_new[MAX_PATTERN-1];
		do_shift = cmp && !hit && !feed.in_last;
	end

	// Result count and job contents
	always_comb begin
		matches_new = (hit && matches_q != CNT_MAX) ? matches_q + CNT_W'(1) : matches_q;
		if (hit)
			nres = rlen;
		else if (feed.in_last)
			nres = fill_new;
		else if (cmp)
			nres = LEN_W'(1);
		else
			nres = '0;
		push_job.chars    = hit ? cfg.replace : win_new;
		push_job.nm1      = (nres == '0) ? '0 : IDX_W'(nres - LEN_W'(1));
		push_job.has_char = (nres != '0);
		push_job.last     = feed.in_last;
		push_job.count    = matches_new;
		push = accept && (nres != '0 || feed.in_last);
	end

	// Window contents
	always_ff @(posedge clk) begin
		if (accept)
			win_q <= do_shift ? win_shift : win_new;
	end

	// Fill level and match counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			matches_q <= '0;
		end else if (accept) begin
			if (feed.in_last || hit)
				fill_q <= '0;
			else if (cmp)
				fill_q <= POS_W'(fill_new - LEN_W'(1));
			else
				fill_q <= POS_W'(fill_new);
			matches_q <= feed.in_last ? '0 : matches_new;
		end
	end

	assign stat.fill      = fill_q;
	assign stat.match_cnt = matches_q;

endmodule

`default_nettype wire

FILE: sv/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue import sfr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	job_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = ent_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_job;
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: sv/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Expands the head job into registered results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back import sfr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire job_t head_job,
	output logic      pop,
	sfr_out_if.source result
);

	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              has_char_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  count_q;
	logic              load, at_end;

	assign load   = head_valid && (!out_valid_q || result.ready);
	assign at_end = (idx_q == head_job.nm1);
	assign pop    = load && at_end;

	// Result index within the head job and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= at_end ? '0 : idx_q + IDX_W'(1);
			if (load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= head_job.has_char ? head_job.chars[idx_q] : '0;
			has_char_q <= head_job.has_char;
			out_last_q <= head_job.last && at_end;
			count_q    <= head_job.count;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_char    = out_char_q;
	assign result.has_char    = has_char_q;
	assign result.out_last    = out_last_q;
	assign result.match_count = count_q;

endmodule

`default_nettype wire

FILE: sv/stream_find_replace_unit.sv
// ----------------------------------------------------------------------------
// stream_find_replace_unit
// Streaming find-and-replace over 16-bit characters with an 8-entry window.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  transfer when
//  feed     in   in_char[15:0], in_last                   valid & ready
//  result   out  out_char[15:0], has_char, out_last,      valid & ready
//                match_count[15:0]
//  cfg      in   index[2:0], data[63:0]                   valid & ready
//
//  The front takes one character per cycle unless the job queue is full;
//  the compare of all window positions is done in the cycle the character
//  is accepted. The back emits one result per cycle unless the output
//  stalls, so an item with several results holds it until all are sent;
//  the two-entry job queue absorbs the difference. The back registers
//  each result. arst_n resets the window fill, match count, queue, output
//  valid and the registers to their reset values; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace_unit import sfr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sfr_in_if.sink    feed,
	sfr_out_if.source result,
	sfr_cfg_if.sink   cfg
);

	logic [CFG_DATA_W-1:0] pattern_low_q, pattern_high_q;
	logic [CFG_DATA_W-1:0] replace_low_q, replace_high_q;
	logic [LEN_W-1:0]      pattern_len_q, replace_len_q;
	logic                  ignore_case_q;

	cfg_t        cfg_cur;
	job_t        push_job, head_job;
	front_stat_t stat;
	logic        push, q_full, pop, head_valid;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			replace_low_q  <= '0;
			replace_high_q <= '0;
			pattern_len_q  <= LEN_W'(1);
			replace_len_q  <= '0;
			ignore_case_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_LOW:  pattern_low_q  <= cfg.data;
				REG_PATTERN_HIGH: pattern_high_q <= cfg.data;
				REG_REPLACE_LOW:  replace_low_q  <= cfg.data;
				REG_REPLACE_HIGH: replace_high_q <= cfg.data;
				REG_PATTERN_LEN:  pattern_len_q  <= cfg.data[LEN_W-1:0];
				REG_REPLACE_LEN:  replace_len_q  <= cfg.data[LEN_W-1:0];
				REG_IGNORE_CASE:  ignore_case_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign cfg_cur.pattern     = {pattern_high_q, pattern_low_q};
	assign cfg_cur.replace     = {replace_high_q, replace_low_q};
	assign cfg_cur.pattern_len = pattern_len_q;
	assign cfg_cur.replace_len = replace_len_q;
	assign cfg_cur.ignore_case = ignore_case_q;

	// Front: window and compare
	sfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.cfg      (cfg_cur),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job),
		.stat     (stat)
	);

	// Job queue
	sfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back: result expansion
	sfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.result     (result)
	);

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("job popped from an empty queue");

	a_empty_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.has_char) |-> (result.out_last && result.out_char == '0))
		else $error("result without a character is not an end marker");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(feed.valid && feed.ready && feed.in_last) |=>
		(stat.fill == '0 && stat.match_cnt == '0))
		else $error("window or count not cleared after the last character");

endmodule

`default_nettype wire
